@@ src/hbwm_pkg.sv @@
// Shared constants, command codes and control structs of the heartbeat watchdog monitor.
package hbwm_pkg;

  localparam int SLOTS_DEF    = 16;
  localparam int AGE_BITS_DEF = 16;

  localparam int CMD_W      = 2;
  localparam int SID_W      = 4;
  localparam int ASSIGN_W   = 4;
  localparam int MASK_W     = 16;
  localparam int TIMEOUT_W  = 16;
  localparam int INTERVAL_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_REGISTER  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HEARTBEAT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_STALE_TIMEOUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_INTERVAL = 2'd1;

  localparam logic [TIMEOUT_W-1:0]  STALE_TIMEOUT_RST  = 16'd10;
  localparam logic [INTERVAL_W-1:0] CHECK_INTERVAL_RST = 8'd1;

  typedef struct packed {
    logic accept;
    logic walk_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic tick_walk;
    logic walk_last;
  } dp_status_t;

endpackage

@@ src/hbwm_in_if.sv @@
// Input channel: one command word per handshake.
interface hbwm_in_if;
  logic                       valid;
  logic                       ready;
  logic [hbwm_pkg::CMD_W-1:0] command;
  logic [hbwm_pkg::SID_W-1:0] slot_id;

  modport source (output valid, output command, output slot_id, input ready);
  modport sink   (input valid, input command, input slot_id, output ready);
endinterface

@@ src/hbwm_out_if.sv @@
// Output channel: one result word per handshake.
interface hbwm_out_if;
  logic                          valid;
  logic                          ready;
  logic [hbwm_pkg::ASSIGN_W-1:0] assigned_slot;
  logic                          registry_full;
  logic                          check_done;
  logic                          pet;
  logic [hbwm_pkg::MASK_W-1:0]   stale_mask;

  modport source (output valid, output assigned_slot, output registry_full,
                  output check_done, output pet, output stale_mask, input ready);
  modport sink   (input valid, input assigned_slot, input registry_full,
                  input check_done, input pet, input stale_mask, output ready);
endinterface

@@ src/hbwm_dp.sv @@
// Datapath: age memory, slot count, tick counter, config registers and result registers.
module hbwm_dp #(
  parameter int SLOTS    = hbwm_pkg::SLOTS_DEF,
  parameter int AGE_BITS = hbwm_pkg::AGE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  hbwm_pkg::dp_cmd_t                  cmd,
  output hbwm_pkg::dp_status_t               status,
  input  logic [hbwm_pkg::CMD_W-1:0]         in_command,
  input  logic [hbwm_pkg::SID_W-1:0]         in_slot_id,
  input  logic                               write_enable,
  input  logic [hbwm_pkg::CFG_IDX_W-1:0]     write_index,
  input  logic [hbwm_pkg::CFG_DATA_W-1:0]    write_data,
  output logic [hbwm_pkg::ASSIGN_W-1:0]      out_assigned_slot,
  output logic                               out_registry_full,
  output logic                               out_check_done,
  output logic                               out_pet,
  output logic [hbwm_pkg::MASK_W-1:0]        out_stale_mask
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = (CNT_W > hbwm_pkg::SID_W) ? CNT_W : hbwm_pkg::SID_W;
  localparam int AW    = (AGE_BITS > hbwm_pkg::TIMEOUT_W) ? AGE_BITS : hbwm_pkg::TIMEOUT_W;
  localparam logic [CNT_W-1:0]    SLOTS_C = CNT_W'(SLOTS);
  localparam logic [AGE_BITS-1:0] AGE_TOP = {AGE_BITS{1'b1}};

  logic [AGE_BITS-1:0] age_mem [SLOTS];

  logic [hbwm_pkg::TIMEOUT_W-1:0]  stale_timeout;
  logic [hbwm_pkg::INTERVAL_W-1:0] check_interval;
  logic [CNT_W-1:0]                slots_used;
  logic [hbwm_pkg::INTERVAL_W-1:0] ticks_since_check;

  logic [IDX_W-1:0]    walk_idx;
  logic [IDX_W-1:0]    pend_idx;
  logic                pend;
  logic [AGE_BITS-1:0] age_rd;

  logic [hbwm_pkg::ASSIGN_W-1:0] res_assigned;
  logic                          res_full;
  logic                          res_done;
  logic                          any_stale;
  logic [hbwm_pkg::MASK_W-1:0]   res_mask;

  logic                            has_room;
  logic                            hb_hit;
  logic [hbwm_pkg::INTERVAL_W-1:0] interval_eff;
  logic [hbwm_pkg::INTERVAL_W-1:0] ticks_next;
  logic                            check_now;
  logic [AGE_BITS-1:0]             age_next;
  logic                            slot_stale;

  always_comb begin
    has_room     = (slots_used < SLOTS_C);
    hb_hit       = (CMP_W'(in_slot_id) < CMP_W'(slots_used));
    interval_eff = (check_interval == '0) ? hbwm_pkg::INTERVAL_W'(1) : check_interval;
    ticks_next   = ticks_since_check + hbwm_pkg::INTERVAL_W'(1);
    check_now    = (ticks_next >= interval_eff);
    age_next     = (age_rd != AGE_TOP) ? age_rd + AGE_BITS'(1) : age_rd;
    slot_stale   = res_done && (AW'(age_next) > AW'(stale_timeout));
    status.tick_walk = (in_command == hbwm_pkg::CMD_TICK) && (slots_used != '0);
    status.walk_last = (CNT_W'(walk_idx) + CNT_W'(1)) == slots_used;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_timeout  <= hbwm_pkg::STALE_TIMEOUT_RST;
      check_interval <= hbwm_pkg::CHECK_INTERVAL_RST;
    end else if (write_enable) begin
      case (write_index)
        hbwm_pkg::REG_STALE_TIMEOUT:  stale_timeout  <= write_data;
        hbwm_pkg::REG_CHECK_INTERVAL: check_interval <= write_data[hbwm_pkg::INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Age memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (pend) begin
      age_mem[pend_idx] <= age_next;
    end else if (cmd.accept) begin
      if (in_command == hbwm_pkg::CMD_REGISTER && has_room) begin
        age_mem[slots_used[IDX_W-1:0]] <= '0;
      end else if (in_command == hbwm_pkg::CMD_HEARTBEAT && hb_hit) begin
        age_mem[IDX_W'(in_slot_id)] <= '0;
      end
    end
    if (cmd.walk_step) begin
      age_rd <= age_mem[walk_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used        <= '0;
      ticks_since_check <= '0;
      pend              <= 1'b0;
    end else begin
      pend <= cmd.walk_step;
      if (cmd.accept) begin
        if (in_command == hbwm_pkg::CMD_REGISTER && has_room) begin
          slots_used <= slots_used + CNT_W'(1);
        end
        if (in_command == hbwm_pkg::CMD_TICK) begin
          ticks_since_check <= check_now ? '0 : ticks_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      walk_idx     <= '0;
      any_stale    <= 1'b0;
      res_mask     <= '0;
      res_assigned <= (in_command == hbwm_pkg::CMD_REGISTER && has_room) ?
                      hbwm_pkg::ASSIGN_W'(slots_used) : '0;
      res_full     <= (in_command == hbwm_pkg::CMD_REGISTER) && !has_room;
      res_done     <= (in_command == hbwm_pkg::CMD_TICK) && check_now;
    end else begin
      if (cmd.walk_step) begin
        walk_idx <= walk_idx + IDX_W'(1);
        pend_idx <= walk_idx;
      end
      // Slots past the mask width shift out and leave only the pet flag.
      if (pend && slot_stale) begin
        any_stale <= 1'b1;
        res_mask  <= res_mask | (hbwm_pkg::MASK_W'(1) << pend_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_assigned_slot <= res_assigned;
      out_registry_full <= res_full;
      out_check_done    <= res_done;
      out_pet           <= res_done && !any_stale;
      out_stale_mask    <= res_mask;
    end
  end

endmodule

@@ src/hbwm_ctrl.sv @@
// Controller: sequences accept, the slot walk and the output handoff.
module hbwm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hbwm_pkg::dp_cmd_t    cmd,
  input  hbwm_pkg::dp_status_t status
);

  typedef enum logic [1:0] {IDLE, WALK, DRAIN, RESULT} state_t;

  state_t state;
  logic   out_free;

  always_comb begin
    in_ready      = (state == IDLE);
    out_free      = !out_valid || out_ready;
    cmd.accept    = (state == IDLE) && in_valid;
    cmd.walk_step = (state == WALK);
    cmd.load_out  = (state == RESULT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            state <= status.tick_walk ? WALK : RESULT;
          end
        end
        WALK: begin
          if (status.walk_last) begin
            state <= DRAIN;
          end
        end
        DRAIN: state <= RESULT;
        RESULT: begin
          // Hold until the output register is free.
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

@@ src/heartbeat_watchdog_monitor_unit.sv @@
// Top level of the heartbeat watchdog monitor: controller plus datapath.
//
//   channel  | kind        | word
//   in_ch    | valid/ready | command, slot_id
//   out_ch   | valid/ready | assigned_slot, registry_full, check_done, pet, stale_mask
//   write_*  | write only  | index 0 stale_timeout, index 1 check_interval
//
// Register, heartbeat, unused commands and a tick with no active slot go from accept
// straight to the result state. A tick with active slots passes through WALK, where the
// age memory's single read port walks them one per cycle, then DRAIN and RESULT. One
// word is in work at a time; the output register holds a finished result while the next
// word is accepted. Reset is synchronous and needs no clearing pass.
module heartbeat_watchdog_monitor_unit #(
  parameter int SLOTS    = hbwm_pkg::SLOTS_DEF,
  parameter int AGE_BITS = hbwm_pkg::AGE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  hbwm_in_if.sink                         in_ch,
  hbwm_out_if.source                      out_ch,
  input  logic                            write_enable,
  input  logic [hbwm_pkg::CFG_IDX_W-1:0]  write_index,
  input  logic [hbwm_pkg::CFG_DATA_W-1:0] write_data
);

  hbwm_pkg::dp_cmd_t    cmd;
  hbwm_pkg::dp_status_t status;

  hbwm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  hbwm_dp #(
    .SLOTS    (SLOTS),
    .AGE_BITS (AGE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .in_command        (in_ch.command),
    .in_slot_id        (in_ch.slot_id),
    .write_enable      (write_enable),
    .write_index       (write_index),
    .write_data        (write_data),
    .out_assigned_slot (out_ch.assigned_slot),
    .out_registry_full (out_ch.registry_full),
    .out_check_done    (out_ch.check_done),
    .out_pet           (out_ch.pet),
    .out_stale_mask    (out_ch.stale_mask)
  );

`ifndef SYNTHESIS
  a_one_word_in_work: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted on two consecutive cycles");

  a_check_excludes_register: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.check_done) |-> (!out_ch.registry_full && out_ch.assigned_slot == '0))
    else $error("check result carries register fields");

  a_pet_means_clean: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.pet) |-> (out_ch.check_done && out_ch.stale_mask == '0))
    else $error("pet raised with stale slots or without a check");
`endif

endmodule
